// ===== rtl/sud_pkg.sv =====
package sud_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

endpackage

// ===== rtl/signed_unsigned_divider_64.sv =====
// Radix-2 restoring divider, 32-bit or MAX_WIDTH-bit operands, signed or unsigned.
// Input channel: raise start with cmd, want_rem, wide, dividend and divisor;
// the item is taken at a clock edge where start is high and busy is low.
// busy stays high from that edge until the result has been shown.
// Output channel: done is high for exactly one cycle with answer and div_zero.
// The receiver cannot stall; the result must be taken in that cycle.
// The dividend sits in a chain of one-bit cells that shifts one place per cycle
// into the partial remainder; one subtract and compare per cycle sets one
// quotient bit, which enters the chain at its low end.
// Steps: load and take magnitudes, then one iteration per quotient bit (32 or
// MAX_WIDTH of them), then the sign fix-up in ST_FIX and the registered output.
// A zero dividend or divisor skips the iterations and returns a zero answer.
// One item at a time; a new item can start the cycle after done.
// Reset (rst, synchronous) returns the block to idle and drops any item.
module signed_unsigned_divider_64 #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic        want_rem,
  input  logic        wide,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] answer,
  output logic        div_zero
);
  import sud_pkg::*;

  localparam int MW = MAX_WIDTH;
  localparam int CW = $clog2(MW + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [MW-1:0] rem;
  logic [MW-1:0] dsr;
  logic [MW-1:0] mask;
  logic          neg_n, neg_d, rem_sel, wide_q, skip, zero_flag;
  logic [MW-1:0] n_in, d_in, sbit;
  logic [MW-1:0] chain;
  logic [MW:0]   carry;
  logic          load, shift;
  logic [MW:0]   trial;
  logic          qbit;
  logic [MW-1:0] q_res, r_res, fix;

  always_comb begin
    if (wide) begin
      mask = '1;
      sbit = {1'b1, {(MW-1){1'b0}}};
    end else begin
      mask = {{(MW-32){1'b0}}, {32{1'b1}}};
      sbit = {{(MW-32){1'b0}}, 1'b1, 31'd0};
    end
    n_in = dividend[MW-1:0] & mask;
    d_in = divisor[MW-1:0] & mask;
  end

  wire n_neg = cmd && ((n_in & sbit) != '0);
  wire d_neg = cmd && ((d_in & sbit) != '0);
  wire [MW-1:0] n_mag = n_neg ? ((~n_in + 1'b1) & mask) : n_in;
  wire [MW-1:0] d_mag = d_neg ? ((~d_in + 1'b1) & mask) : d_in;

  assign load  = start && !busy;
  assign shift = (state == ST_RUN);

  // the top cell of the used width feeds the remainder
  wire top_bit = wide_q ? chain[MW-1] : chain[31];

  assign trial = {rem, top_bit} - {1'b0, dsr};
  assign qbit  = ~trial[MW] | rem[MW-1];
  assign carry[0] = qbit;

  genvar gi;
  generate
    for (gi = 0; gi < MW; gi++) begin : g_cell
      sud_cell u_cell (
        .clk      (clk),
        .load     (load),
        .shift    (shift),
        .load_val (n_mag[gi]),
        .carry_in (carry[gi]),
        .carry_out(carry[gi+1]),
        .bit_out  (chain[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem       <= '0;
      dsr       <= d_mag;
      neg_n     <= n_neg;
      neg_d     <= d_neg;
      rem_sel   <= want_rem;
      wide_q    <= wide;
      skip      <= (n_in == '0) || (d_in == '0);
      zero_flag <= (n_in != '0) && (d_in == '0);
      count     <= wide ? CW'(MW) : CW'(32);
    end else if (shift) begin
      rem   <= qbit ? trial[MW-1:0] : {rem[MW-2:0], top_bit};
      count <= count - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start && !done) state_next = ST_RUN;
      ST_RUN:  if (skip || count == CW'(1)) state_next = ST_FIX;
      ST_FIX:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_res = wide_q ? chain : (chain & {{(MW-32){1'b0}}, {32{1'b1}}});
    r_res = rem;
    if (rem_sel) begin
      fix = neg_n ? (~r_res + 1'b1) : r_res;
    end else begin
      fix = (neg_n != neg_d) ? (~q_res + 1'b1) : q_res;
    end
    if (!wide_q) begin
      fix = fix & {{(MW-32){1'b0}}, {32{1'b1}}};
    end
    if (skip) begin
      fix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIX) begin
      answer   <= 64'(fix);
      div_zero <= zero_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FIX);
    end
  end

  assign busy = (state != ST_IDLE) || done;
endmodule

// ===== rtl/sud_cell.sv =====
module sud_cell (
  input  logic         clk,
  input  logic         load,
  input  logic         shift,
  input  logic         load_val,
  input  logic         carry_in,
  output logic         carry_out,
  output logic         bit_out
);
  logic bit_q;

  always_ff @(posedge clk) begin
    if (load) begin
      bit_q <= load_val;
    end else if (shift) begin
      bit_q <= carry_in;
    end
  end

  assign bit_out   = bit_q;
  assign carry_out = bit_q;
endmodule

// ===== tb/sv/signed_unsigned_divider_64_tb.sv =====
module signed_unsigned_divider_64_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class div_scoreboard;
    logic [63:0] quo_q[$];
    logic        zero_q[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function void note_item(logic is_signed, logic rem, logic wide_op,
                            logic [63:0] a, logic [63:0] b);
      logic [63:0] mask, sbit, n, d, q, r, ans;
      logic        neg_n, neg_d, top;
      int          w;
      w = wide_op ? 64 : 32;
      mask = wide_op ? '1 : 64'h0000_0000_FFFF_FFFF;
      sbit = 64'd1 << (w - 1);
      n = a & mask;
      d = b & mask;
      neg_n = 0;
      neg_d = 0;
      if (n == 0) begin
        quo_q.push_back('0);
        zero_q.push_back(1'b0);
        return;
      end
      if (d == 0) begin
        quo_q.push_back('0);
        zero_q.push_back(1'b1);
        return;
      end
      if (is_signed) begin
        if (n & sbit) begin
          neg_n = 1;
          n = (-n) & mask;
        end
        if (d & sbit) begin
          neg_d = 1;
          d = (-d) & mask;
        end
      end
      q = 0;
      r = 0;
      for (int i = w - 1; i >= 0; i--) begin
        top = r[63];
        r = {r[62:0], n[i]};
        if (top || r >= d) begin
          r = r - d;
          q[i] = 1'b1;
        end
      end
      if (rem) ans = neg_n ? -r : r;
      else ans = (neg_n != neg_d) ? -q : q;
      quo_q.push_back(ans & mask);
      zero_q.push_back(1'b0);
    endfunction

    function void check_result(logic [63:0] got, logic got_zero);
      logic [63:0] exp_ans;
      logic        exp_zero;
      if (quo_q.size() == 0) begin
        $error("unexpected result answer=%h", got);
        errors++;
        return;
      end
      exp_ans = quo_q.pop_front();
      exp_zero = zero_q.pop_front();
      if (got !== exp_ans) begin
        $error("answer: expected %h actual %h", exp_ans, got);
        errors++;
      end
      if (got_zero !== exp_zero) begin
        $error("div_zero: expected %b actual %b", exp_zero, got_zero);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst, start, busy, cmd, want_rem, wide, done, div_zero;
  logic [63:0] dividend, divisor, answer;
  int          idle_pct;
  div_scoreboard sb;

  signed_unsigned_divider_64 u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .want_rem(want_rem), .wide(wide), .dividend(dividend), .divisor(divisor),
    .done(done), .answer(answer), .div_zero(div_zero)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(answer, div_zero);
  end

  task automatic send_item(logic s, logic r, logic w, logic [63:0] a, logic [63:0] b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd <= s;
    want_rem <= r;
    wide <= w;
    dividend <= a;
    divisor <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(s, r, w, a, b);
  endtask

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h0000_0000_8000_0000;
      4: return {$urandom, $urandom} >> $urandom_range(63);
      5: return 64'd1 + $urandom_range(3);
      6: return -(64'd1 + $urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.quo_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [63:0] ops[8];
    sb = new();
    idle_pct = 0;
    rst = 1;
    start = 0;
    cmd = 0;
    want_rem = 0;
    wide = 0;
    dividend = 0;
    divisor = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;
    ops = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
            64'hFFFF_FFFF_8000_0000, 64'h1234_5678_FFFF_FFFF, 64'd7};
    for (int k = 0; k < 24; k++)
      send_item(k[0], k[1], k[2], ops[(k * 3) % 8], ops[(k * 5 + 1) % 8]);
    send_item(1'b1, 1'b0, 1'b0, 64'hFFFF_0000_8000_0000, 64'h0000_0000_FFFF_FFFF);
    drain();
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 3) ? 25 : 64;
      for (int k = 0; k < 300; k++)
        send_item($urandom_range(1), $urandom_range(1), $urandom_range(1),
                  pick_operand(), pick_operand());
      drain();
    end
    repeat (80) @(negedge clk);
    if (sb.errors == 0 && sb.quo_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
